/* hdl/dad_pkg.sv */
// Shared types, widths and calendar helpers for the date add unit.
package dad_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int OFF_W   = 16;
    // running day sum: start day plus offset, signed
    localparam int ACC_W   = OFF_W + 1;

    localparam logic [MONTH_W-1:0] JAN = 4'd1;
    localparam logic [MONTH_W-1:0] FEB = 4'd2;
    localparam logic [MONTH_W-1:0] DEC = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_MIN = 12'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX = 12'd4095;

    typedef struct packed {
        logic load;   // take a new item into the datapath
        logic step;   // advance one month forward or backward
    } t_dp_cmd;

    typedef struct packed {
        logic done;   // date is normalized or has run out of range
    } t_dp_stat;

    // Length of a month (1..12); leap when year divisible by four.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                    input logic [YEAR_W-1:0] year);
        logic [DAY_W-1:0] len;
        unique case (month)
            4'd2:                                 len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:              len = 5'd30;
            default:                              len = 5'd31;
        endcase
        if (month == FEB && year[1:0] == 2'b00) begin
            len = 5'd29;
        end
        return len;
    endfunction

endpackage

/* hdl/date_add_days_top.sv */
// Top level of the date add unit: moves a calendar date by a signed day count.
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------------
//  input    | start, busy       | i_start_day, i_start_month, i_start_year,
//           |                   | i_day_offset
//  result   | o_valid (strobe)  | o_result_day, o_result_month, o_result_year,
//           |                   | o_range_error
//
// An item is taken when start is high and busy is low. The walk moves one
// month per clock in the datapath until the date has settled, and the
// controller then registers the result strobe.
// o_valid is high for one cycle and the receiver cannot hold it off; a new item
// may be started in that same cycle. Reset is synchronous, active low, and
// clears the controller; a year leaving 1..4095 ends the walk with range_error.
module date_add_days_top import dad_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [DAY_W-1:0]        i_start_day,
    input  logic [MONTH_W-1:0]      i_start_month,
    input  logic [YEAR_W-1:0]       i_start_year,
    input  logic signed [OFF_W-1:0] i_day_offset,
    output logic                    o_valid,
    output logic [DAY_W-1:0]        o_result_day,
    output logic [MONTH_W-1:0]      o_result_month,
    output logic [YEAR_W-1:0]       o_result_year,
    output logic                    o_range_error
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencing: load, step until normalized, strobe
    dad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // day/month/year walk
    dad_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_start_day    (i_start_day),
        .i_start_month  (i_start_month),
        .i_start_year   (i_start_year),
        .i_day_offset   (i_day_offset),
        .o_stat         (dp_stat),
        .o_result_day   (o_result_day),
        .o_result_month (o_result_month),
        .o_result_year  (o_result_year),
        .o_range_error  (o_range_error)
    );

    // a result follows a busy walk, never overlaps it
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy && $past(busy))
        else $error("result strobe without a preceding walk");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // a good result is a real calendar date
    a_result_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_range_error |->
            o_result_day != 5'd0 && o_result_month != 4'd0
            && o_result_month <= DEC && o_result_year != 12'd0
            && o_result_day <= month_len(o_result_month, o_result_year))
        else $error("normalized date out of calendar range");

endmodule

/* hdl/dad_dp.sv */
// Datapath: day accumulator, month and year registers, one month per step.
module dad_dp import dad_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic [DAY_W-1:0]        i_start_day,
    input  logic [MONTH_W-1:0]      i_start_month,
    input  logic [YEAR_W-1:0]       i_start_year,
    input  logic signed [OFF_W-1:0] i_day_offset,
    output t_dp_stat                o_stat,
    output logic [DAY_W-1:0]        o_result_day,
    output logic [MONTH_W-1:0]      o_result_month,
    output logic [YEAR_W-1:0]       o_result_year,
    output logic                    o_range_error
);

    logic signed [ACC_W-1:0] r_day,   n_day;
    logic [MONTH_W-1:0]      r_month, n_month;
    logic [YEAR_W-1:0]       r_year,  n_year;
    logic                    r_err,   n_err;
    logic [DAY_W-1:0]        r_sd;
    logic [MONTH_W-1:0]      r_sm;
    logic [YEAR_W-1:0]       r_sy;

    logic [DAY_W-1:0]        len_cur, len_prev;
    logic [MONTH_W-1:0]      prev_month, clamp_month;
    logic [YEAR_W-1:0]       prev_year;
    logic                    too_big, too_small;

    assign len_cur    = month_len(r_month, r_year);
    assign prev_month = (r_month == JAN) ? DEC : r_month - 4'd1;
    assign prev_year  = (r_month == JAN) ? r_year - 12'd1 : r_year;
    assign len_prev   = month_len(prev_month, prev_year);

    assign too_big   = r_day > $signed({{(ACC_W-DAY_W){1'b0}}, len_cur});
    assign too_small = r_day < $signed(ACC_W'(1));

    assign clamp_month = (i_start_month == 4'd0) ? JAN :
                         (i_start_month > DEC)   ? DEC : i_start_month;

    always_comb begin
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_err   = r_err;
        if (i_cmd.load) begin
            n_day   = $signed({{(ACC_W-DAY_W){1'b0}}, i_start_day})
                    + $signed({i_day_offset[OFF_W-1], i_day_offset});
            n_month = clamp_month;
            n_year  = i_start_year;
            n_err   = (i_start_year == 12'd0);
        end else if (i_cmd.step) begin
            if (too_big) begin
                n_day = r_day - $signed({{(ACC_W-DAY_W){1'b0}}, len_cur});
                if (r_month == DEC) begin
                    n_month = JAN;
                    n_year  = r_year + 12'd1;
                    n_err   = (r_year == YEAR_MAX);
                end else begin
                    n_month = r_month + 4'd1;
                end
            end else if (too_small) begin
                // going below year 1 stops the walk at once
                n_month = prev_month;
                n_year  = prev_year;
                if (r_month == JAN && r_year == YEAR_MIN) begin
                    n_err = 1'b1;
                end else begin
                    n_day = r_day + $signed({{(ACC_W-DAY_W){1'b0}}, len_prev});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else begin
            r_err <= n_err;
        end
        r_day   <= n_day;
        r_month <= n_month;
        r_year  <= n_year;
        if (i_cmd.load) begin
            r_sd <= i_start_day;
            r_sm <= i_start_month;
            r_sy <= i_start_year;
        end
    end

    assign o_stat.done    = r_err || (!too_big && !too_small);
    assign o_result_day   = r_err ? r_sd : r_day[DAY_W-1:0];
    assign o_result_month = r_err ? r_sm : r_month;
    assign o_result_year  = r_err ? r_sy : r_year;
    assign o_range_error  = r_err;

endmodule

/* hdl/dad_ctrl.sv */
// Controller: accepts items, steps the datapath, strobes the result.
module dad_ctrl import dad_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_busy,  n_busy;
    logic   r_valid, n_valid;

    assign o_cmd.load = i_start && !r_busy;
    assign o_cmd.step = (r_state == S_RUN) && !i_stat.done;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE, S_RESP: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_busy  = 1'b1;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                if (i_stat.done) begin
                    n_state = S_RESP;
                    n_busy  = 1'b0;
                    n_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule
